FILE: design/ffsp_pkg.sv
// Shared types, constants and codes of the first-fit shelf packer.
package ffsp_pkg;

    localparam int MAX_LEVELS = 64;
    localparam int LVL_W      = $clog2(MAX_LEVELS);
    localparam int CNT_W      = $clog2(MAX_LEVELS + 1);
    localparam int DIM_W      = 16;
    localparam int SUM_W      = 22;

    localparam logic [DIM_W-1:0] MAX_WIDTH_RST = 16'd1024;

    localparam logic       MODE_PLACE  = 1'b0;
    localparam logic       MODE_FINISH = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // sources for the pending place/empty-finish result
    localparam logic [2:0] PEND_BAD   = 3'd0;
    localparam logic [2:0] PEND_FULL  = 3'd1;
    localparam logic [2:0] PEND_EMPTY = 3'd2;
    localparam logic [2:0] PEND_NEW   = 3'd3;
    localparam logic [2:0] PEND_FIT   = 3'd4;

    typedef struct packed {
        logic             mode;
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
    } t_in_beat;

    typedef struct packed {
        logic [LVL_W-1:0] level_index;
        logic [DIM_W-1:0] x_offset;
        logic [SUM_W-1:0] floor_y;
        logic [1:0]       status;
        logic [DIM_W-1:0] sheet_width;
        logic [SUM_W-1:0] sheet_height;
        logic             last;
    } t_out_beat;

    typedef struct packed {
        logic       latch;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_next;
        logic       pend_ld;
        logic [2:0] pend_sel;
        logic       tot_clr;
        logic       tot_acc;
        logic       fy_clr;
        logic       emit;
        logic       post;
        logic       clear_sheet;
    } t_cmd;

    typedef struct packed {
        logic is_finish;
        logic bad;
        logic cnt_zero;
        logic fits;
        logic at_last;
        logic tbl_full;
        logic out_free;
    } t_stat;

endpackage

FILE: design/ffsp_ctrl.sv
// Controller state machine of the first-fit shelf packer.
module ffsp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ffsp_pkg::t_stat i_stat,
    output ffsp_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);
    import ffsp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_FREAD  = 3'd4;
    localparam logic [2:0] S_FEMIT  = 3'd5;
    localparam logic [2:0] S_POST   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_finish) begin
                    if (i_stat.cnt_zero) begin
                        o_cmd.pend_ld     = 1'b1;
                        o_cmd.pend_sel    = PEND_EMPTY;
                        o_cmd.clear_sheet = 1'b1;
                        n_state           = S_POST;
                    end else begin
                        o_cmd.tot_clr = 1'b1;
                        n_state       = S_SUM;
                    end
                end else if (i_stat.bad) begin
                    o_cmd.pend_ld  = 1'b1;
                    o_cmd.pend_sel = PEND_BAD;
                    n_state        = S_POST;
                end else if (i_stat.cnt_zero) begin
                    o_cmd.pend_ld  = 1'b1;
                    o_cmd.pend_sel = PEND_NEW;
                    n_state        = S_POST;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_next = 1'b1;
                if (i_stat.fits) begin
                    o_cmd.pend_ld  = 1'b1;
                    o_cmd.pend_sel = PEND_FIT;
                    n_state        = S_POST;
                end else if (i_stat.at_last) begin
                    o_cmd.pend_ld  = 1'b1;
                    o_cmd.pend_sel = i_stat.tbl_full ? PEND_FULL : PEND_NEW;
                    n_state        = S_POST;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_SUM: begin
                o_cmd.rd_next = 1'b1;
                o_cmd.tot_acc = 1'b1;
                if (i_stat.at_last) begin
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.fy_clr  = 1'b1;
                    n_state       = S_FREAD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_FREAD: begin
                n_state = S_FEMIT;
            end
            S_FEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.at_last) begin
                        o_cmd.clear_sheet = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_FREAD;
                    end
                end
            end
            S_POST: begin
                if (i_stat.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: design/ffsp_dpath.sv
// Datapath of the first-fit shelf packer: level tables, counters and output register.
module ffsp_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ffsp_pkg::t_cmd     i_cmd,
    output ffsp_pkg::t_stat    o_stat,
    input  ffsp_pkg::t_in_beat i_in_beat,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output ffsp_pkg::t_out_beat o_out_beat
);
    import ffsp_pkg::*;

    logic [DIM_W-1:0] mem_end [MAX_LEVELS];
    logic [DIM_W-1:0] mem_hgt [MAX_LEVELS];
    logic [DIM_W-1:0] r_end_q;
    logic [DIM_W-1:0] r_hgt_q;

    logic [DIM_W-1:0] r_max_width;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [DIM_W-1:0] r_widest;
    logic [DIM_W-1:0] n_widest;
    logic [LVL_W-1:0] r_idx;
    logic [LVL_W-1:0] n_idx;
    logic             r_out_vld;
    logic             n_out_vld;

    logic             r_mode;
    logic [DIM_W-1:0] r_w;
    logic [DIM_W-1:0] r_h;
    logic [SUM_W-1:0] r_total;
    logic [SUM_W-1:0] r_fy;
    t_out_beat        r_pend;
    t_out_beat        n_pend;
    t_out_beat        r_out;
    t_out_beat        floor_beat;

    logic [LVL_W-1:0] rd_addr;
    logic             wr_en;
    logic [LVL_W-1:0] wr_addr;
    logic [DIM_W-1:0] wr_end;
    logic [DIM_W-1:0] wr_hgt;
    logic [DIM_W:0]   ex;
    logic [DIM_W-1:0] hgt_max;
    logic [DIM_W-1:0] new_wide;
    logic [DIM_W-1:0] fit_wide;
    logic [CNT_W-1:0] idx_p1;

    assign idx_p1   = {1'b0, r_idx} + CNT_W'(1);
    assign ex       = {1'b0, r_end_q} + {1'b0, r_w};
    assign hgt_max  = (r_h > r_hgt_q) ? r_h : r_hgt_q;
    assign new_wide = (r_w > r_widest) ? r_w : r_widest;
    assign fit_wide = (ex[DIM_W-1:0] > r_widest) ? ex[DIM_W-1:0] : r_widest;
    assign rd_addr  = i_cmd.rd_next ? idx_p1[LVL_W-1:0] : r_idx;

    // status back to the controller
    assign o_stat.is_finish = (r_mode == MODE_FINISH);
    assign o_stat.bad       = (r_w == '0) || (r_h == '0) || (r_w > r_max_width);
    assign o_stat.cnt_zero  = (r_count == '0);
    assign o_stat.fits      = (ex <= {1'b0, r_max_width});
    assign o_stat.at_last   = (idx_p1 == r_count);
    assign o_stat.tbl_full  = (r_count == CNT_W'(MAX_LEVELS));
    assign o_stat.out_free  = !r_out_vld || !i_out_stall;

    always_comb begin
        n_pend  = '0;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_end  = ex[DIM_W-1:0];
        wr_hgt  = hgt_max;
        unique case (i_cmd.pend_sel)
            PEND_BAD: begin
                n_pend.status      = ST_BAD;
                n_pend.sheet_width = r_widest;
                n_pend.last        = 1'b1;
            end
            PEND_FULL: begin
                n_pend.status      = ST_FULL;
                n_pend.sheet_width = r_widest;
                n_pend.last        = 1'b1;
            end
            PEND_EMPTY: begin
                n_pend.last = 1'b1;
            end
            PEND_NEW: begin
                n_pend.level_index = r_count[LVL_W-1:0];
                n_pend.status      = ST_OK;
                n_pend.sheet_width = new_wide;
                n_pend.last        = 1'b1;
                wr_en              = i_cmd.pend_ld;
                wr_addr            = r_count[LVL_W-1:0];
                wr_end             = r_w;
                wr_hgt             = r_h;
            end
            PEND_FIT: begin
                n_pend.level_index = r_idx;
                n_pend.x_offset    = r_end_q;
                n_pend.status      = ST_OK;
                n_pend.sheet_width = fit_wide;
                n_pend.last        = 1'b1;
                wr_en              = i_cmd.pend_ld;
            end
            default: begin
                n_pend = '0;
            end
        endcase
    end

    always_comb begin
        floor_beat              = '0;
        floor_beat.level_index  = r_idx;
        floor_beat.floor_y      = r_fy;
        floor_beat.status       = ST_OK;
        floor_beat.sheet_width  = r_widest;
        floor_beat.sheet_height = r_total;
        floor_beat.last         = o_stat.at_last;
    end

    always_comb begin
        n_count  = r_count;
        n_widest = r_widest;
        n_idx    = r_idx;
        if (i_cmd.pend_ld && (i_cmd.pend_sel == PEND_NEW)) begin
            n_count  = r_count + CNT_W'(1);
            n_widest = new_wide;
        end else if (i_cmd.pend_ld && (i_cmd.pend_sel == PEND_FIT)) begin
            n_widest = fit_wide;
        end
        if (i_cmd.clear_sheet) begin
            n_count  = '0;
            n_widest = '0;
        end
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = idx_p1[LVL_W-1:0];
        end
        n_out_vld = (r_out_vld && i_out_stall) || i_cmd.post || i_cmd.emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width <= MAX_WIDTH_RST;
            r_count     <= '0;
            r_widest    <= '0;
            r_idx       <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_width <= i_cfg_data;
            end
            r_count   <= n_count;
            r_widest  <= n_widest;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_in_beat.mode;
            r_w    <= i_in_beat.rect_width;
            r_h    <= i_in_beat.rect_height;
        end
        if (i_cmd.tot_clr) begin
            r_total <= '0;
        end else if (i_cmd.tot_acc) begin
            r_total <= r_total + SUM_W'(r_hgt_q);
        end
        if (i_cmd.fy_clr) begin
            r_fy <= '0;
        end else if (i_cmd.emit) begin
            r_fy <= r_fy + SUM_W'(r_hgt_q);
        end
        if (i_cmd.pend_ld) begin
            r_pend <= n_pend;
        end
        if (i_cmd.post) begin
            r_out <= r_pend;
        end else if (i_cmd.emit) begin
            r_out <= floor_beat;
        end
    end

    // level tables: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_end[wr_addr] <= wr_end;
            mem_hgt[wr_addr] <= wr_hgt;
        end
        r_end_q <= mem_end[rd_addr];
        r_hgt_q <= mem_hgt[rd_addr];
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

endmodule

FILE: design/first_fit_shelf_packer.sv
// Top level of the first-fit shelf packer: controller, datapath and checks.
//
// Usage: items arrive on the input channel (i_in_valid / o_in_stall, payload
// i_in_beat) and results leave on the output channel (o_out_valid /
// i_out_stall, payload o_out_beat). A beat moves on an edge with valid high
// and stall low. max_width is written through i_cfg_we / i_cfg_data, by the
// user only while idle: the block does not enforce it. One item is in work
// at a time; a finished result waits in the output register, so the next
// item is taken while that beat is still stalled. Place: accept (IDLE) and
// decode (DECODE), then a first-fit scan, one level per cycle, through the
// level table read port (at most 64), then the result to the output register.
// Finish with n > 0 levels: heights summed one level per cycle (SUM), then each
// level read (FREAD) and emitted (FEMIT) as one floor beat, the last flagged.
// Reset (synchronous, active low) empties the level table by clearing the
// level count and widest end, and sets max_width to 1024; the table
// contents are not cleared and need no clearing pass.
// A stalled receiver holds the current beat; the block then waits with its
// next result and does not drop or repeat any beat.
module first_fit_shelf_packer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ffsp_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ffsp_pkg::t_out_beat o_out_beat,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data
);
    import ffsp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: scan, sum and emit passes
    ffsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // level tables, running sums and the output register
    ffsp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_beat   (i_in_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

    // never load the output register over a beat that is still held
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit || cmd.post) |-> stat.out_free)
        else $error("output register loaded while a stalled beat is held");

    // an accepted item keeps the input side stalled on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again straight after an accept");

    // error statuses only come from place items, which give one beat
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.status != ST_OK)) |-> o_out_beat.last)
        else $error("error status on a beat that is not last");

    // clearing the sheet empties the level count
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_sheet |=> stat.cnt_zero)
        else $error("level count not cleared after finish");

endmodule

FILE: sim/first_fit_shelf_packer_checker.sv
// Scoreboard for the shelf packer: predicts every result beat and compares it.
`timescale 1ns / 1ps

module first_fit_shelf_packer_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  ffsp_pkg::t_in_beat  i_in_beat,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  ffsp_pkg::t_out_beat i_out_beat,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import ffsp_pkg::*;

    logic [DIM_W-1:0] width_limit;
    logic [DIM_W-1:0] shelf_end    [MAX_LEVELS];
    logic [DIM_W-1:0] shelf_height [MAX_LEVELS];
    logic [CNT_W-1:0] shelf_count;
    logic [DIM_W-1:0] widest;
    t_out_beat        owed_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Work out the result beats of one accepted item and advance the shelf state.
    task automatic pack_item(input t_in_beat item);
        t_out_beat        res;
        logic [DIM_W:0]   reach;
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] floor_acc;
        bit               placed;
        res      = '0;
        res.last = 1'b1;
        if (item.mode == MODE_PLACE) begin
            if (item.rect_width == '0 || item.rect_height == '0 ||
                item.rect_width > width_limit) begin
                res.status      = ST_BAD;
                res.sheet_width = widest;
                owed_results.push_back(res);
                return;
            end
            placed = 1'b0;
            for (int lvl = 0; lvl < shelf_count && !placed; lvl++) begin
                reach = {1'b0, shelf_end[lvl]} + {1'b0, item.rect_width};
                if (reach <= {1'b0, width_limit}) begin
                    res.level_index = LVL_W'(lvl);
                    res.x_offset    = shelf_end[lvl];
                    shelf_end[lvl]  = reach[DIM_W-1:0];
                    if (item.rect_height > shelf_height[lvl])
                        shelf_height[lvl] = item.rect_height;
                    if (reach[DIM_W-1:0] > widest)
                        widest = reach[DIM_W-1:0];
                    placed = 1'b1;
                end
            end
            if (!placed) begin
                if (shelf_count >= CNT_W'(MAX_LEVELS)) begin
                    res.status = ST_FULL;
                end else begin
                    res.level_index           = shelf_count[LVL_W-1:0];
                    shelf_end[shelf_count]    = item.rect_width;
                    shelf_height[shelf_count] = item.rect_height;
                    shelf_count               = shelf_count + CNT_W'(1);
                    if (item.rect_width > widest)
                        widest = item.rect_width;
                end
            end
            res.sheet_width = widest;
            owed_results.push_back(res);
        end else begin
            if (shelf_count == '0) begin
                owed_results.push_back(res);
            end else begin
                total = '0;
                for (int lvl = 0; lvl < shelf_count; lvl++)
                    total += SUM_W'(shelf_height[lvl]);
                floor_acc = '0;
                for (int lvl = 0; lvl < shelf_count; lvl++) begin
                    res.level_index  = LVL_W'(lvl);
                    res.floor_y      = floor_acc;
                    res.sheet_width  = widest;
                    res.sheet_height = total;
                    res.last         = (lvl + 1 == shelf_count);
                    owed_results.push_back(res);
                    floor_acc += SUM_W'(shelf_height[lvl]);
                end
            end
            shelf_count = '0;
            widest      = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            width_limit = MAX_WIDTH_RST;
            shelf_count = '0;
            widest      = '0;
            owed_results.delete();
        end else begin
            // compare the outgoing beat first: it belongs to an earlier item
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("level_index",  32'(want.level_index),
                                32'(i_out_beat.level_index));
                    check_field("x_offset",     32'(want.x_offset),
                                32'(i_out_beat.x_offset));
                    check_field("floor_y",      32'(want.floor_y),
                                32'(i_out_beat.floor_y));
                    check_field("status",       32'(want.status),
                                32'(i_out_beat.status));
                    check_field("sheet_width",  32'(want.sheet_width),
                                32'(i_out_beat.sheet_width));
                    check_field("sheet_height", 32'(want.sheet_height),
                                32'(i_out_beat.sheet_height));
                    check_field("last",         32'(want.last),
                                32'(i_out_beat.last));
                end
            end
            if (i_cfg_we)
                width_limit = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                pack_item(i_in_beat);
        end
        o_pending = owed_results.size();
    end

endmodule

FILE: sim/first_fit_shelf_packer_tb.sv
// Testbench top: clock, reset, stimulus and verdict for the shelf packer.
`timescale 1ns / 1ps

module first_fit_shelf_packer_tb;
    import ffsp_pkg::*;

    // Watchdog limit, set far above the slowest sane run.
    localparam int CYCLE_LIMIT = 400000;
    // Longest item is a full 64-level finish; let that much settle at the end.
    localparam int SETTLE_CYCLES = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_beat    in_beat;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_beat   out_beat;
    logic        cfg_we;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          quiet = 1'b0;
    int          run_left = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    first_fit_shelf_packer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    first_fit_shelf_packer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: give up on a hung block.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver back-pressure: alternate calm runs with random stall bursts, so
    // stalls land on every phase of a finish sweep. Hold off once the run goes
    // quiet.
    always @(negedge i_clk) begin
        if (quiet) begin
            out_stall <= 1'b0;
            run_left  <= 0;
        end else if (run_left != 0) begin
            run_left <= run_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            out_stall <= 1'b1;
            run_left  <= $urandom_range(0, 15);
        end else begin
            out_stall <= 1'b0;
            run_left  <= $urandom_range(0, 23);
        end
    end

    // Offer one beat and hold it until the block takes it. Called and left at a
    // falling edge; valid stays high into the next item unless a gap is drawn.
    task automatic send_item(input logic mode, input logic [15:0] w,
                             input logic [15:0] h);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_beat.mode        = mode;
        in_beat.rect_width  = w;
        in_beat.rect_height = h;
        in_valid            = 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every owed result beat, then wait out the spare cycles.
    task automatic drain(input int spare);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (spare) @(negedge i_clk);
    endtask

    task automatic write_max_width(input logic [15:0] value);
        cfg_data = value;
        cfg_we   = 1'b1;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    // Mostly widths that fit a few to a shelf; some zero, exact-fit, just too
    // wide or fully random.
    function automatic logic [15:0] pick_width(input logic [15:0] limit);
        int sel;
        sel = $urandom_range(0, 9);
        unique case (sel)
            0:       pick_width = '0;
            1:       pick_width = 16'($urandom_range(0, 65535));
            2:       pick_width = limit;
            3:       pick_width = (limit == 16'hFFFF) ? limit : limit + 16'd1;
            default: pick_width = 16'($urandom_range(1, (limit > 4) ? limit / 4 : 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_height();
        pick_height = ($urandom_range(0, 15) == 0) ? 16'd0
                                                   : 16'($urandom_range(1, 65535));
    endfunction

    task automatic random_item(input logic [15:0] limit);
        logic mode;
        mode = ($urandom_range(0, 11) == 0) ? MODE_FINISH : MODE_PLACE;
        send_item(mode, pick_width(limit), pick_height());
    endtask

    initial begin
        logic [15:0] limit;
        int          good_places;
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_beat  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset width of 1024, empty finish, every bad-size form,
        // exact fits, height growth and a four-shelf finish.
        send_item(MODE_FINISH, 16'd0, 16'd0);
        send_item(MODE_PLACE, 16'd0, 16'd5);
        send_item(MODE_PLACE, 16'd5, 16'd0);
        send_item(MODE_PLACE, 16'd1025, 16'd1);
        send_item(MODE_PLACE, 16'hFFFF, 16'hFFFF);
        send_item(MODE_PLACE, 16'd1024, 16'hFFFF);
        send_item(MODE_PLACE, 16'd1, 16'd1);
        send_item(MODE_PLACE, 16'd1023, 16'd3);
        send_item(MODE_PLACE, 16'd512, 16'd7);
        send_item(MODE_PLACE, 16'd512, 16'd9);
        send_item(MODE_PLACE, 16'd1, 16'd2);
        send_item(MODE_FINISH, 16'hFFFF, 16'hFFFF);
        send_item(MODE_FINISH, 16'd0, 16'd0);
        drain(8);

        // Zero width limit: everything is too wide.
        write_max_width(16'd0);
        send_item(MODE_PLACE, 16'd1, 16'd1);
        send_item(MODE_PLACE, 16'hFFFF, 16'd1);
        drain(8);

        // Widest limit: full-width rectangles each open a shelf of their own.
        write_max_width(16'hFFFF);
        send_item(MODE_PLACE, 16'hFFFF, 16'hFFFF);
        send_item(MODE_PLACE, 16'hFFFF, 16'd1);
        send_item(MODE_PLACE, 16'd1, 16'd1);
        send_item(MODE_FINISH, 16'd0, 16'd0);

        // Random, widest limit, with the odd finish mixed in.
        for (int n = 0; n < 20; n++)
            random_item(16'hFFFF);
        send_item(MODE_FINISH, 16'd0, 16'd0);
        drain(8);

        // Limit of one: every good rectangle opens a shelf, so fill the table,
        // run into the full case, then finish with all 64 shelves.
        write_max_width(16'd1);
        good_places = 0;
        while (good_places < 66) begin
            if ($urandom_range(0, 7) == 0) begin
                random_item(16'd1);
            end else begin
                send_item(MODE_PLACE, 16'd1, 16'($urandom_range(1, 65535)));
                good_places++;
            end
        end
        send_item(MODE_FINISH, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
        drain(8);

        // Random mid-range limit; the second half runs with no idling at all.
        limit = 16'($urandom_range(2, 3000));
        write_max_width(limit);
        for (int n = 0; n < 40; n++) begin
            if (n == 20)
                quiet = 1'b1;
            random_item(limit);
        end
        send_item(MODE_FINISH, 16'd0, 16'd0);

        drain(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
